[rtl/ddt_pkg.sv]
// Shared types and constants of the disparity to depth distance unit.
// No dependencies.
`timescale 1ns / 1ps
package ddt_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned SQ_STAGES = 31;
  localparam int unsigned DIV_BITS  = 41;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FOCAL  = 2'd2,
    CFG_BASE   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] focal;
    logic [15:0] base;
  } cfg_t;

  typedef struct packed {
    logic        zero;
    logic [15:0] disp;
    logic [31:0] fb;
  } side_t;

  typedef struct packed {
    logic        zero;
    logic [15:0] disp;
    logic [40:0] num_dp;
    logic [40:0] num_eu;
  } div_in_t;

  typedef struct packed {
    logic        zero;
    logic [40:0] q_dp;
    logic [40:0] q_eu;
  } div_out_t;

endpackage

[rtl/disparity_to_depth_distance_unit.sv]
// Disparity to depth and Euclidean distance, top level.
// Pipeline: 3 front stages, 31 root stages, 1 product, 41 divide, 1 output.
// Throughput one word per cycle; the whole pipeline holds while a valid output word is stalled.
// Reset clears all valid bits and loads the register defaults 640, 480, 8000, 100.
// Depends on ddt_pkg, ddt_front, ddt_sqrt, ddt_mul, ddt_div.
`timescale 1ns / 1ps
module disparity_to_depth_distance_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] disparity_value_i,
  input  logic [11:0] pixel_column_i,
  input  logic [11:0] pixel_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] axial_depth_o,
  output logic [31:0] euclid_distance_o,
  output logic        invalid_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ddt_pkg::*;

  cfg_t        cfg_q;
  logic [12:0] dim_v, dim_c;
  logic        en;
  logic        fv, sv, mv, dv;
  logic [33:0] s;
  side_t       side_f, side_s;
  logic [30:0] root;
  div_in_t     div_in;
  div_out_t    res;
  logic        sat;
  logic        ov_q;
  logic [31:0] dep_q, eu_q;
  logic        inv_q;

  assign cfg_ready_o = 1'b1;
  assign dim_v = cfg_data_i[12:0];
  assign dim_c = (dim_v > 13'(MAX_DIM)) ? 13'(MAX_DIM) : dim_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 13'd640;
      cfg_q.height <= 13'd480;
      cfg_q.focal  <= 16'd8000;
      cfg_q.base   <= 16'd100;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH:  cfg_q.width  <= dim_c;
        CFG_HEIGHT: cfg_q.height <= dim_c;
        CFG_FOCAL:  cfg_q.focal  <= cfg_data_i;
        CFG_BASE:   cfg_q.base   <= cfg_data_i;
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  assign en         = !(ov_q && out_stall_i);
  assign in_stall_o = !en;

  ddt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .disp_i  (disparity_value_i),
    .col_i   (pixel_column_i),
    .row_i   (pixel_row_i),
    .cfg_i   (cfg_q),
    .valid_o (fv),
    .s_o     (s),
    .side_o  (side_f)
  );

  ddt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .s_i     (s),
    .side_i  (side_f),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (side_s)
  );

  ddt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .root_i  (root),
    .base_i  (cfg_q.base),
    .side_i  (side_s),
    .valid_o (mv),
    .div_o   (div_in)
  );

  ddt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mv),
    .div_i   (div_in),
    .valid_o (dv),
    .res_o   (res)
  );

  assign sat = res.zero || (res.q_dp[40:32] != '0) || (res.q_eu[40:32] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dep_q <= sat ? '1 : res.q_dp[31:0];
      eu_q  <= sat ? '1 : res.q_eu[31:0];
      inv_q <= sat;
    end
  end

  assign out_valid_o       = ov_q;
  assign axial_depth_o     = dep_q;
  assign euclid_distance_o = eu_q;
  assign invalid_flag_o    = inv_q;

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_flag_o |-> axial_depth_o == '1 && euclid_distance_o == '1)
    else $error("invalid word without saturated outputs");

  a_eu_ge_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_flag_o |-> euclid_distance_o >= axial_depth_o)
    else $error("distance below depth");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("pipeline advanced under output stall");

endmodule

[rtl/ddt_front.sv]
// Front stages: centre offsets, squares, focal products and radicand.
// Depends on ddt_pkg.
`timescale 1ns / 1ps
module ddt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [15:0]     disp_i,
  input  logic [11:0]     col_i,
  input  logic [11:0]     row_i,
  input  ddt_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output logic [33:0]     s_o,
  output ddt_pkg::side_t  side_o
);
  import ddt_pkg::*;

  logic [12:0] tx, ty, ox_d, oy_d;
  logic [12:0] ox_q, oy_q;
  logic [15:0] disp_a_q;
  logic        va_q, vb_q, vc_q;
  logic [25:0] sqx, sqy;
  logic [26:0] sq_q;
  logic [31:0] ff_q;
  side_t       side_b_q, side_c_q;
  logic [33:0] s_q;

  assign tx   = {col_i, 1'b0};
  assign ty   = {row_i, 1'b0};
  assign ox_d = (tx >= cfg_i.width)  ? tx - cfg_i.width  : cfg_i.width - tx;
  assign oy_d = (ty >= cfg_i.height) ? ty - cfg_i.height : cfg_i.height - ty;
  assign sqx  = ox_q * ox_q;
  assign sqy  = oy_q * oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q          <= ox_d;
      oy_q          <= oy_d;
      disp_a_q      <= disp_i;
      sq_q          <= {1'b0, sqx} + {1'b0, sqy};
      ff_q          <= cfg_i.focal * cfg_i.focal;
      side_b_q.zero <= (disp_a_q == 16'd0);
      side_b_q.disp <= disp_a_q;
      side_b_q.fb   <= cfg_i.focal * cfg_i.base;
      s_q           <= {1'b0, sq_q, 6'b0} + {2'b0, ff_q};
      side_c_q      <= side_b_q;
    end
  end

  assign valid_o = vc_q;
  assign s_o     = s_q;
  assign side_o  = side_c_q;

endmodule

[rtl/ddt_sqrt.sv]
// Pipelined integer square root of S * 2^28, one result bit per stage.
// Depends on ddt_pkg.
`timescale 1ns / 1ps
module ddt_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [33:0]     s_i,
  input  ddt_pkg::side_t  side_i,
  output logic            valid_o,
  output logic [30:0]     root_o,
  output ddt_pkg::side_t  side_o
);
  import ddt_pkg::*;

  logic        v_q    [SQ_STAGES];
  logic [32:0] rem_q  [SQ_STAGES];
  logic [30:0] root_q [SQ_STAGES];
  logic [33:0] s_q    [SQ_STAGES];
  side_t       sd_q   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic        v_in;
    logic [32:0] rem_in;
    logic [30:0] root_in;
    logic [33:0] s_in;
    side_t       sd_in;
    logic [61:0] m;
    logic [34:0] cur, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = s_i;
      assign sd_in   = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
      assign sd_in   = sd_q[k-1];
    end

    assign m     = {s_in, 28'b0};
    assign cur   = {rem_in, m[61-2*k -: 2]};
    assign trial = {2'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 33'(cur - trial) : cur[32:0];
        root_q[k] <= {root_in[29:0], ge};
        s_q[k]    <= s_in;
        sd_q[k]   <= sd_in;
      end
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1];
  assign side_o  = sd_q[SQ_STAGES-1];

endmodule

[rtl/ddt_mul.sv]
// Product of the root and the baseline, and the depth numerator, registered.
// Depends on ddt_pkg.
`timescale 1ns / 1ps
module ddt_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [30:0]       root_i,
  input  logic [15:0]       base_i,
  input  ddt_pkg::side_t    side_i,
  output logic              valid_o,
  output ddt_pkg::div_in_t  div_o
);
  import ddt_pkg::*;

  logic [46:0] prod;
  logic        v_q;
  div_in_t     div_q;

  assign prod = root_i * base_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q.zero   <= side_i.zero;
      div_q.disp   <= side_i.disp;
      div_q.num_dp <= {1'b0, side_i.fb, 8'b0};
      div_q.num_eu <= prod[46:6];
    end
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

[rtl/ddt_div.sv]
// Two-lane pipelined restoring divider sharing one divisor, one bit per stage.
// Depends on ddt_pkg.
`timescale 1ns / 1ps
module ddt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ddt_pkg::div_in_t   div_i,
  output logic               valid_o,
  output ddt_pkg::div_out_t  res_o
);
  import ddt_pkg::*;

  logic          v_q    [DIV_BITS];
  div_in_t       in_q   [DIV_BITS];
  logic [15:0]   rdp_q  [DIV_BITS];
  logic [15:0]   reu_q  [DIV_BITS];
  logic [40:0]   qdp_q  [DIV_BITS];
  logic [40:0]   qeu_q  [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
    logic        v_in;
    div_in_t     d_in;
    logic [15:0] rdp_in, reu_in;
    logic [40:0] qdp_in, qeu_in;
    logic [16:0] cdp, ceu, dv;
    logic        gdp, geu;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign d_in   = div_i;
      assign rdp_in = '0;
      assign reu_in = '0;
      assign qdp_in = '0;
      assign qeu_in = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign d_in   = in_q[j-1];
      assign rdp_in = rdp_q[j-1];
      assign reu_in = reu_q[j-1];
      assign qdp_in = qdp_q[j-1];
      assign qeu_in = qeu_q[j-1];
    end

    assign dv  = {1'b0, d_in.disp};
    assign cdp = {rdp_in, d_in.num_dp[DIV_BITS-1-j]};
    assign ceu = {reu_in, d_in.num_eu[DIV_BITS-1-j]};
    assign gdp = (cdp >= dv);
    assign geu = (ceu >= dv);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        in_q[j]  <= d_in;
        rdp_q[j] <= gdp ? 16'(cdp - dv) : cdp[15:0];
        reu_q[j] <= geu ? 16'(ceu - dv) : ceu[15:0];
        qdp_q[j] <= {qdp_in[39:0], gdp};
        qeu_q[j] <= {qeu_in[39:0], geu};
      end
    end
  end

  assign valid_o    = v_q[DIV_BITS-1];
  assign res_o.zero = in_q[DIV_BITS-1].zero;
  assign res_o.q_dp = qdp_q[DIV_BITS-1];
  assign res_o.q_eu = qeu_q[DIV_BITS-1];

endmodule
